// File: design/smx_pkg.sv
// ----------------------------------------------------------------------------
// smx_pkg
// Shared constants, types and the exponent table for the row softmax block.
// ----------------------------------------------------------------------------
package smx_pkg;

   localparam int MAX_ROW_DEF = 64;

   // log2(e) in Q.20
   localparam logic [20:0] LOG2E_Q20 = 21'd1512775;

   // quotient bits of the probability divide, one above the Q0.16 range
   localparam int QUOT_W = 17;
   // width of e (Q0.16 with room for 1.0)
   localparam int EXP_W = 17;

   typedef logic [EXP_W-1:0] exp_tab_type [256];

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_READ,
      ST_MUL,
      ST_EXP,
      ST_ACC,
      ST_DSTART,
      ST_DIV,
      ST_OUT
   } state_type;

   // 2^(-f/256) in Q0.16, rounded to nearest, from a Q0.64 series of exp(-x)
   function automatic exp_tab_type build_exp_tab();
      exp_tab_type   tab;
      logic [63:0]   x;
      logic [63:0]   term;
      logic [63:0]   pos;
      logic [63:0]   neg;
      logic [63:0]   r;
      logic [127:0]  wide;
      tab[0] = 17'd65536;
      for (int f = 1; f < 256; f++) begin
         x    = (64'hB17217F7D1CF79AC >> 8) * 64'(f);
         term = x;
         pos  = 64'd0;
         neg  = x;
         for (int k = 2; k < 24; k++) begin
            wide = {64'd0, term} * {64'd0, x};
            term = wide[127:64] / 64'(k);
            if (k % 2 == 1) begin
               neg = neg + term;
            end else begin
               pos = pos + term;
            end
         end
         r      = 64'd0 - neg + pos;
         r      = (r + (64'd1 << 47)) >> 48;
         tab[f] = r[EXP_W-1:0];
      end
      return tab;
   endfunction

   localparam exp_tab_type EXP_TAB = build_exp_tab();

endpackage

// File: design/smx_exp_unit.sv
// ----------------------------------------------------------------------------
// smx_exp_unit
// Two-stage exponent unit: e = 2^(-(max-x)*log2e) in Q0.16.
// ----------------------------------------------------------------------------
module smx_exp_unit (
   input  logic                        clock,
   input  logic signed [15:0]          score,
   input  logic signed [15:0]          row_max,
   output logic [smx_pkg::EXP_W-1:0]   exp_val
);

   logic [15:0]                  diff;
   logic [36:0]                  prod_in;
   logic [36:0]                  prod_ff;
   logic [36:0]                  t_full;
   logic [16:0]                  t_q8;
   logic [8:0]                   shift_amt;
   logic [7:0]                   frac;
   logic [smx_pkg::EXP_W-1:0]    exp_in;
   logic [smx_pkg::EXP_W-1:0]    exp_ff;

   assign diff    = row_max - score;
   assign prod_in = 37'(diff) * 37'(smx_pkg::LOG2E_Q20);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      exp_ff  <= exp_in;
   end

   always_comb begin
      t_full    = prod_ff + (37'd1 << 19);
      t_q8      = t_full[36:20];
      shift_amt = t_q8[16:8];
      frac      = t_q8[7:0];
      if (shift_amt >= 9'd17) begin
         exp_in = '0;
      end else begin
         exp_in = smx_pkg::EXP_TAB[frac] >> shift_amt;
      end
   end

   assign exp_val = exp_ff;

endmodule

// File: design/smx_divider.sv
// ----------------------------------------------------------------------------
// smx_divider
// Restoring divider, one quotient bit per cycle, 17-bit quotient.
// ----------------------------------------------------------------------------
module smx_divider #(
   parameter int SUM_W = 23
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [33:0]                  numer,
   input  logic [SUM_W-1:0]             denom,
   output logic                         done,
   output logic [smx_pkg::QUOT_W-1:0]   quot
);

   localparam int QW = smx_pkg::QUOT_W;

   logic [SUM_W:0]     rem_ff, rem_in;
   logic [QW-1:0]      low_ff, low_in;
   logic [QW-1:0]      quot_ff, quot_in;
   logic [4:0]         cnt_ff, cnt_in;
   logic               done_ff, done_in;
   logic [SUM_W:0]     trial;

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      low_ff  <= low_in;
      quot_ff <= quot_in;
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   always_comb begin
      rem_in  = rem_ff;
      low_in  = low_ff;
      quot_in = quot_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      trial   = {rem_ff[SUM_W-1:0], low_ff[QW-1]};
      if (start) begin
         // high part of the numerator is below the divisor
         rem_in = (SUM_W+1)'(numer[33:QW]);
         low_in = numer[QW-1:0];
         cnt_in = 5'(QW);
      end else if (cnt_ff != '0) begin
         if (trial >= (SUM_W+1)'(denom)) begin
            rem_in  = trial - (SUM_W+1)'(denom);
            quot_in = {quot_ff[QW-2:0], 1'b1};
         end else begin
            rem_in  = trial;
            quot_in = {quot_ff[QW-2:0], 1'b0};
         end
         low_in  = {low_ff[QW-2:0], 1'b0};
         cnt_in  = cnt_ff - 5'd1;
         done_in = (cnt_ff == 5'd1);
      end
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule

// File: design/softmax_row_forward.sv
// ----------------------------------------------------------------------------
// softmax_row_forward
// Row softmax over signed Q8.8 scores, Q0.16 probabilities out.
// ----------------------------------------------------------------------------
// Scores load at one beat per cycle into a MAX_ROW-entry buffer while the
// running maximum is tracked; beats past MAX_ROW are dropped and flag overflow
// on every result of that row. The row_end beat starts two passes over the
// buffer with req_ready low: a sum pass over each entry (buffer read,
// multiply, table and shift, accumulate) and an output pass over each entry
// (exponent recomputed, divider start, 17 quotient bits and the done state,
// then the result beat, which waits for rsp_ready).
module softmax_row_forward #(
   parameter int MAX_ROW = smx_pkg::MAX_ROW_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic signed [15:0]  req_score,
   input  logic                req_row_end,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [15:0]         rsp_prob,
   output logic                rsp_last_out,
   output logic                rsp_overflow
);

   localparam int AW    = (MAX_ROW > 1) ? $clog2(MAX_ROW) : 1;
   localparam int CW    = $clog2(MAX_ROW + 1);
   localparam int SUM_W = smx_pkg::EXP_W + AW;
   localparam int QW    = smx_pkg::QUOT_W;

   smx_pkg::state_type state_ff, state_in;

   logic [15:0]               mem [MAX_ROW];
   logic signed [15:0]        rdata_ff;
   logic [CW-1:0]             count_ff, count_in;
   logic signed [15:0]        max_ff, max_in;
   logic [SUM_W-1:0]          sum_ff, sum_in;
   logic                      drop_ff, drop_in;
   logic [AW-1:0]             idx_ff, idx_in;
   logic                      pass_ff, pass_in;
   logic [15:0]               prob_ff, prob_in;

   logic                      mem_we;
   logic [smx_pkg::EXP_W-1:0] exp_val;
   logic                      div_start;
   logic                      div_done;
   logic [QW-1:0]             quot;
   logic [33:0]               numer;
   logic                      is_last;
   logic                      accept;

   smx_exp_unit u_exp (
      .clock   (clock),
      .score   (rdata_ff),
      .row_max (max_ff),
      .exp_val (exp_val)
   );

   smx_divider #(.SUM_W(SUM_W)) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .numer (numer),
      .denom (sum_ff),
      .done  (div_done),
      .quot  (quot)
   );

   assign numer   = {1'b0, exp_val, 16'd0} + 34'(sum_ff >> 1);
   assign is_last = (CW'(idx_ff) + CW'(1)) == count_ff;
   assign accept  = req_valid && req_ready;
   assign mem_we  = accept && (count_ff < CW'(MAX_ROW));

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[count_ff[AW-1:0]] <= req_score;
      end
      rdata_ff <= mem[idx_ff];
   end

   always_ff @(posedge clock) begin
      sum_ff  <= sum_in;
      idx_ff  <= idx_in;
      prob_ff <= prob_in;
      if (reset) begin
         state_ff <= smx_pkg::ST_LOAD;
         count_ff <= '0;
         max_ff   <= 16'sh8000;
         drop_ff  <= 1'b0;
         pass_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         max_ff   <= max_in;
         drop_ff  <= drop_in;
         pass_ff  <= pass_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      max_in    = max_ff;
      sum_in    = sum_ff;
      drop_in   = drop_ff;
      idx_in    = idx_ff;
      pass_in   = pass_ff;
      prob_in   = prob_ff;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      div_start = 1'b0;
      unique case (state_ff)
         smx_pkg::ST_LOAD: begin
            req_ready = 1'b1;
            if (accept) begin
               if (mem_we) begin
                  count_in = count_ff + CW'(1);
                  if (req_score > max_ff) begin
                     max_in = req_score;
                  end
               end else begin
                  drop_in = 1'b1;
               end
               if (req_row_end) begin
                  idx_in   = '0;
                  sum_in   = '0;
                  pass_in  = 1'b0;
                  state_in = smx_pkg::ST_READ;
               end
            end
         end
         smx_pkg::ST_READ: state_in = smx_pkg::ST_MUL;
         smx_pkg::ST_MUL:  state_in = smx_pkg::ST_EXP;
         smx_pkg::ST_EXP: begin
            state_in = pass_ff ? smx_pkg::ST_DSTART : smx_pkg::ST_ACC;
         end
         smx_pkg::ST_ACC: begin
            sum_in   = sum_ff + SUM_W'(exp_val);
            state_in = smx_pkg::ST_READ;
            if (is_last) begin
               idx_in  = '0;
               pass_in = 1'b1;
            end else begin
               idx_in = idx_ff + AW'(1);
            end
         end
         smx_pkg::ST_DSTART: begin
            div_start = 1'b1;
            state_in  = smx_pkg::ST_DIV;
         end
         smx_pkg::ST_DIV: begin
            if (div_done) begin
               // saturate at 65535
               prob_in  = quot[QW-1] ? 16'hFFFF : quot[15:0];
               state_in = smx_pkg::ST_OUT;
            end
         end
         smx_pkg::ST_OUT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               if (is_last) begin
                  count_in = '0;
                  max_in   = 16'sh8000;
                  sum_in   = '0;
                  drop_in  = 1'b0;
                  pass_in  = 1'b0;
                  idx_in   = '0;
                  state_in = smx_pkg::ST_LOAD;
               end else begin
                  idx_in   = idx_ff + AW'(1);
                  state_in = smx_pkg::ST_READ;
               end
            end
         end
         default: state_in = smx_pkg::ST_LOAD;
      endcase
   end

   assign rsp_prob     = prob_ff;
   assign rsp_last_out = is_last;
   assign rsp_overflow = drop_ff;

endmodule

// File: bench/tb_softmax_row_forward.sv
// ----------------------------------------------------------------------------
// tb_softmax_row_forward
// Self-checking bench for the row softmax block.
// ----------------------------------------------------------------------------
// Score beats are pushed from a queue by a clocked driver with random gaps;
// a clocked monitor compares each probability beat against a predictor that
// keeps its own copy of the row buffer, maximum and exponent table.
module tb_softmax_row_forward;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ROW_DEPTH = smx_pkg::MAX_ROW_DEF;

   typedef struct packed {
      logic [15:0] score;
      logic        row_end;
   } score_beat_type;

   typedef struct packed {
      logic [15:0] prob;
      logic        last_out;
      logic        overflow;
   } prob_beat_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [15:0] req_score = '0;
   logic        req_row_end = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [15:0] rsp_prob;
   logic        rsp_last_out;
   logic        rsp_overflow;

   softmax_row_forward #(.MAX_ROW(ROW_DEPTH)) i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_score(req_score), .req_row_end(req_row_end),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_prob(rsp_prob), .rsp_last_out(rsp_last_out),
      .rsp_overflow(rsp_overflow)
   );

   always #2 clock = ~clock;

   score_beat_type pending_scores[$];
   prob_beat_type  expected_probs[$];
   int          error_count = 0;
   int          beats_sent = 0;
   int          probs_seen = 0;
   int          rows_closed = 0;
   int          overflow_rows = 0;
   bit          calm = 1'b0;
   bit          hold_send = 1'b0;

   // predictor state
   logic [16:0]        pow2_tab [256];
   logic signed [15:0] row_buf [ROW_DEPTH];
   int                 row_len = 0;
   logic signed [15:0] row_peak = -16'sd32768;
   bit                 row_dropped = 1'b0;

   function automatic logic [16:0] exp_of_score(logic signed [15:0] x);
      logic [15:0] d;
      logic [63:0] t;
      logic [63:0] n;
      d = 16'(row_peak - x);
      t = (64'(d) * 64'd1512775 + (64'd1 << 19)) >> 20;
      n = t >> 8;
      if (n >= 17) return 17'd0;
      return pow2_tab[t[7:0]] >> n;
   endfunction

   task automatic predict_beat(score_beat_type b);
      logic [63:0] total;
      logic [63:0] e;
      logic [63:0] p;
      prob_beat_type r;
      if (row_len < ROW_DEPTH) begin
         row_buf[row_len] = signed'(b.score);
         row_len++;
         if (signed'(b.score) > row_peak) row_peak = signed'(b.score);
      end else begin
         row_dropped = 1'b1;
      end
      if (!b.row_end) return;
      total = 0;
      for (int i = 0; i < row_len; i++) total += exp_of_score(row_buf[i]);
      for (int i = 0; i < row_len; i++) begin
         e = exp_of_score(row_buf[i]);
         p = (total != 0) ? ((e << 16) + (total >> 1)) / total : 0;
         if (p > 65535) p = 65535;
         r.prob = p[15:0];
         r.last_out = (i + 1 == row_len);
         r.overflow = row_dropped;
         expected_probs.push_back(r);
      end
      rows_closed++;
      if (row_dropped) overflow_rows++;
      row_len = 0;
      row_peak = -16'sd32768;
      row_dropped = 1'b0;
   endtask

   // Q0.64 series for 2^(-f/256), rounded to Q0.16
   task automatic fill_pow2_tab();
      logic [63:0]  x, term, pos, neg, r;
      logic [127:0] wide;
      pow2_tab[0] = 17'd65536;
      for (int f = 1; f < 256; f++) begin
         x = (64'hB17217F7D1CF79AC >> 8) * 64'(f);
         term = x;
         pos = 0;
         neg = x;
         for (int k = 2; k < 24; k++) begin
            wide = {64'd0, term} * {64'd0, x};
            term = wide[127:64] / 64'(k);
            if (k % 2 == 1) neg += term;
            else pos += term;
         end
         r = 64'd0 - neg + pos;
         r = (r + (64'd1 << 47)) >> 48;
         pow2_tab[f] = r[16:0];
      end
   endtask

   function automatic score_beat_type mk(logic [15:0] s, logic e);
      score_beat_type b;
      b.score = s;
      b.row_end = e;
      return b;
   endfunction

   task automatic push_row(int len, int mode);
      logic [15:0] base;
      base = 16'($urandom);
      for (int i = 0; i < len; i++) begin
         case (mode)
            0: pending_scores.push_back(mk(16'($urandom), i == len - 1));
            1: pending_scores.push_back(
                  mk(base + 16'($urandom_range(0, 1023)) - 16'd512, i == len - 1));
            default: pending_scores.push_back(
                  mk(16'($urandom_range(0, 1) ? 16'h7fff : 16'h8000), i == len - 1));
         endcase
      end
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (req_valid) begin
            predict_beat({req_score, req_row_end});
            beats_sent++;
         end
         if (pending_scores.size() != 0 && !hold_send
             && (calm || $urandom_range(0, 99) >= 23)) begin
            score_beat_type b;
            b = pending_scores.pop_front();
            req_valid <= 1'b1;
            req_score <= b.score;
            req_row_end <= b.row_end;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            probs_seen++;
            if (expected_probs.size() == 0) begin
               error_count++;
               $display("%0t: unexpected beat prob=%0d last=%0b ovf=%0b", $realtime,
                        rsp_prob, rsp_last_out, rsp_overflow);
            end else begin
               prob_beat_type x;
               x = expected_probs.pop_front();
               if (x.prob !== rsp_prob || x.last_out !== rsp_last_out
                   || x.overflow !== rsp_overflow) begin
                  error_count++;
                  $display({"%0t: mismatch expected prob=%0d last=%0b ovf=%0b,",
                            " got prob=%0d last=%0b ovf=%0b"},
                           $realtime, x.prob, x.last_out, x.overflow,
                           rsp_prob, rsp_last_out, rsp_overflow);
               end
            end
         end
         rsp_ready <= calm || ($urandom_range(0, 99) >= 23);
      end
   end

   initial begin
      #20ms;
      $display("TEST FAILED");
      $finish;
   end

   initial begin
      int guard;
      fill_pow2_tab();
      // directed rows
      pending_scores.push_back(mk(16'h0000, 1'b1));           // single-entry row
      pending_scores.push_back(mk(16'h7fff, 1'b0));           // extreme spread
      pending_scores.push_back(mk(16'h8000, 1'b1));
      pending_scores.push_back(mk(16'h1234, 1'b0));           // equal scores
      pending_scores.push_back(mk(16'h1234, 1'b0));
      pending_scores.push_back(mk(16'h1234, 1'b1));
      pending_scores.push_back(mk(16'h0100, 1'b0));           // small and large differences
      pending_scores.push_back(mk(16'h0000, 1'b0));
      pending_scores.push_back(mk(16'hff00, 1'b0));
      pending_scores.push_back(mk(16'h5555, 1'b0));
      pending_scores.push_back(mk(16'haaaa, 1'b1));
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      // full row, then a row that overflows with the drop on row end
      push_row(ROW_DEPTH, 1);
      push_row(ROW_DEPTH + 3, 0);
      while (pending_scores.size() != 0) @(posedge clock);
      // pause until the block has drained
      hold_send <= 1'b1;
      while (expected_probs.size() != 0 || req_valid) @(posedge clock);
      hold_send <= 1'b0;
      for (int k = 0; k < 30; k++) begin
         int m;
         m = $urandom_range(0, 8);
         // every tenth row runs around the buffer size
         if (k % 10 == 9) begin
            push_row($urandom_range(ROW_DEPTH - 2, ROW_DEPTH + 4),
                     $urandom_range(0, 1));
         end else if (m < 6) begin
            push_row($urandom_range(1, 8), 1);
         end else if (m < 8) begin
            push_row($urandom_range(1, 12), 0);
         end else begin
            push_row($urandom_range(1, 4), 2);
         end
         if (k == 20) begin
            calm <= 1'b1;
            while (pending_scores.size() != 0) @(posedge clock);
            calm <= 1'b0;
         end
      end
      while (pending_scores.size() != 0 || req_valid) @(posedge clock);
      guard = 0;
      while (expected_probs.size() != 0 && guard < 200000) begin
         @(posedge clock);
         guard++;
      end
      repeat (50) @(posedge clock);
      $display("sent %0d score beats in %0d rows (%0d overflowed), checked %0d probabilities",
               beats_sent, rows_closed, overflow_rows, probs_seen);
      if (error_count == 0 && expected_probs.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// File: softmax_row_forward.f
design/smx_pkg.sv
design/smx_exp_unit.sv
design/smx_divider.sv
design/softmax_row_forward.sv
bench/tb_softmax_row_forward.sv
